### hdl/midi_note_to_frequency_top_macros.svh
// Assertion macros used by the checker file of the note-to-frequency block.
`ifndef MIDI_NOTE_TO_FREQUENCY_TOP_MACROS_SVH
`define MIDI_NOTE_TO_FREQUENCY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define MNTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define MNTF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mntf_pkg.sv
// Package with the types, constants and helper function of the note-to-frequency block.
`default_nettype none

package mntf_pkg;

  // Fixed-point formats of the note and of the frequency.
  localparam int NOTE_FRAC_BITS = 8;
  localparam int HZ_FRAC_BITS   = 12;

  // Field widths.
  localparam int NOTE_W = 20;
  localparam int FREQ_W = 29;
  localparam int SR_W   = 18;

  // Configuration port.
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [SR_W-1:0]      SR_RESET        = 18'd44100;

  // One octave (twelve semitones) in note units and the depth of the exponent table.
  localparam int SEMI_DEN  = 12 << NOTE_FRAC_BITS;
  localparam int TBL_DEPTH = SEMI_DEN;
  localparam int R_W       = $clog2(TBL_DEPTH);

  // Note split: d = note - 69 semitones, q = floor(d / SEMI_DEN), r = d mod SEMI_DEN.
  localparam int D_W          = NOTE_W + 1;
  localparam int DIV_SHIFT    = NOTE_FRAC_BITS + 2;
  localparam int X_W          = D_W - DIV_SHIFT;
  localparam int Q_W          = 9;
  localparam logic [D_W-1:0] NOTE_OFFSET = D_W'(69 << NOTE_FRAC_BITS);
  // Bias that makes floor(d / 1024) non-negative; a multiple of three.
  localparam int X_BIAS       = 531;
  localparam int Q_BIAS       = X_BIAS / 3;
  // floor(u / 3) as (u * RECIP3) >> RECIP3_SHIFT, exact for u below 2^17.
  localparam int RECIP3_SHIFT = 17;
  localparam int RECIP3       = ((1 << RECIP3_SHIFT) + 1) / 3;
  localparam int RECIP3_W     = 16;

  // Mantissa m = 2^(r / SEMI_DEN) in unsigned Q1.62.
  localparam int M_W = 63;
  localparam logic [M_W-1:0] ONE_Q62 = {1'b1, 62'd0};

  // Scaling by 440 Hz and the final shift.
  localparam int FREQ_A4    = 440;
  localparam int P_W        = M_W + 9;
  localparam int Q_OVER     = 20;
  localparam int SHIFT_BASE = 62 - HZ_FRAC_BITS;
  localparam int SH_W       = 8;
  localparam int T_W        = P_W - (SHIFT_BASE - Q_OVER + 1);

  // Taylor series engine that builds the exponent table.
  localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] EXP_STEP = LN2_Q64 / 64'(4 * SEMI_DEN);
  localparam int Y_W       = 62;
  localparam int CHUNK_W   = 16;
  localparam int PP_W      = M_W + CHUNK_W;
  localparam int ACC_W     = M_W + Y_W;
  localparam int DVD_W     = 62;
  localparam int DIV_STEPS = DVD_W;
  localparam int K_W       = 5;
  localparam logic [K_W-1:0] K_MAX = 5'd30;

  typedef struct packed {
    logic signed [NOTE_W-1:0] note;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic              clamped;
    logic              last_out;
  } out_item_t;

  // Write port of the exponent table.
  typedef struct packed {
    logic           en;
    logic [R_W-1:0] addr;
    logic [M_W-1:0] data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    FILL_START,
    FILL_MUL,
    FILL_DIV,
    FILL_ACC,
    FILL_WRITE,
    FILL_DONE
  } fill_state_t;

  // Nyquist bound (sample_rate / 2 - 1) in hertz with HZ_FRAC_BITS fraction bits.
  function automatic logic [FREQ_W-1:0] calc_top(input logic [SR_W-1:0] sr);
    logic [FREQ_W-1:0] half;
    half = FREQ_W'({sr, {(HZ_FRAC_BITS-1){1'b0}}});
    if (sr < SR_W'(2)) begin
      return '0;
    end
    return half - FREQ_W'(1 << HZ_FRAC_BITS);
  endfunction

endpackage

`default_nettype wire

### hdl/mntf_apb_regs.sv
// Configuration register file with the sample rate and the derived Nyquist bound.
`default_nettype none

module mntf_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mntf_pkg::APB_AW-1:0] paddr,
  input  wire logic [mntf_pkg::APB_DW-1:0] pwdata,
  output logic      [mntf_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output logic      [mntf_pkg::FREQ_W-1:0] top
);
  import mntf_pkg::*;

  logic [SR_W-1:0]      sr_r;
  logic [FREQ_W-1:0]    top_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_sr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];

  // Decode a write that completes this cycle.
  always_comb begin
    wr_sr = 1'b0;
    unique case (reg_idx)
      REG_SAMPLE_RATE: wr_sr = psel && penable && pwrite;
      default:         wr_sr = 1'b0;
    endcase
  end

  // The bound is worked out once at write time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r  <= SR_RESET;
      top_r <= calc_top(SR_RESET);
    end else if (wr_sr) begin
      sr_r  <= pwdata[SR_W-1:0];
      top_r <= calc_top(pwdata[SR_W-1:0]);
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_RATE: prdata = APB_DW'(sr_r);
      default:         prdata = '0;
    endcase
  end

  assign top = top_r;

endmodule

`default_nettype wire

### hdl/mntf_taylor_fill.sv
// Sequencer that builds the 2^(r/3072) table from a Taylor series after reset.
`default_nettype none

module mntf_taylor_fill (
  input  wire logic              clk,
  input  wire logic              rst_n,
  output mntf_pkg::tbl_wr_t      wr,
  output logic                   done
);
  import mntf_pkg::*;

  fill_state_t          state_r, state_nxt;
  logic [R_W-1:0]       entry_r;
  logic [Y_W-1:0]       y_r;
  logic [M_W-1:0]       term_r;
  logic [M_W-1:0]       sum_r;
  logic [K_W-1:0]       k_r;
  logic [1:0]           mcnt_r;
  logic [$clog2(DIV_STEPS)-1:0] dcnt_r;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [K_W-1:0]       rem_r, rem_nxt;
  logic [CHUNK_W*4-1:0] y_ext;
  logic [CHUNK_W-1:0]   chunk;
  logic [PP_W-1:0]      pp;
  logic [K_W:0]         trial;
  logic [K_W:0]         diff;
  logic                 ge;

  // Multiply term by y sixteen bits of y at a time, high chunk first.
  always_comb begin
    y_ext = (CHUNK_W*4)'(y_r);
    case (mcnt_r)
      2'd0:    chunk = y_ext[4*CHUNK_W-1 -: CHUNK_W];
      2'd1:    chunk = y_ext[3*CHUNK_W-1 -: CHUNK_W];
      2'd2:    chunk = y_ext[2*CHUNK_W-1 -: CHUNK_W];
      default: chunk = y_ext[CHUNK_W-1:0];
    endcase
    pp      = PP_W'(term_r) * PP_W'(chunk);
    acc_nxt = {acc_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(pp);
  end

  // One restoring division step by k per cycle.
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    ge      = trial >= {1'b0, k_r};
    diff    = trial - {1'b0, k_r};
    rem_nxt = ge ? diff[K_W-1:0] : trial[K_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FILL_START: state_nxt = FILL_MUL;
      FILL_MUL: begin
        if (mcnt_r == 2'd3) state_nxt = FILL_DIV;
      end
      FILL_DIV: begin
        if (dcnt_r == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) state_nxt = FILL_ACC;
      end
      FILL_ACC: begin
        if ((k_r == K_MAX) || (dvd_r == '0)) state_nxt = FILL_WRITE;
        else state_nxt = FILL_MUL;
      end
      FILL_WRITE: begin
        if (entry_r == R_W'(TBL_DEPTH - 1)) state_nxt = FILL_DONE;
        else state_nxt = FILL_START;
      end
      FILL_DONE: state_nxt = FILL_DONE;
      default:   state_nxt = FILL_START;
    endcase
  end

  // Outputs.
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = entry_r;
    wr.data = sum_r;
    done    = 1'b0;
    unique case (state_r)
      FILL_WRITE: wr.en = 1'b1;
      FILL_DONE:  done  = 1'b1;
      default: begin
        wr.en = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL_START;
      entry_r <= '0;
      y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FILL_WRITE) begin
        entry_r <= entry_r + R_W'(1);
        y_r     <= y_r + EXP_STEP[Y_W-1:0];
      end
    end
  end

  // Series datapath: term_k = floor(floor(term_(k-1) * y / 2^62) / k).
  always_ff @(posedge clk) begin
    case (state_r)
      FILL_START: begin
        term_r <= ONE_Q62;
        sum_r  <= ONE_Q62;
        k_r    <= K_W'(1);
        mcnt_r <= 2'd0;
        acc_r  <= '0;
      end
      FILL_MUL: begin
        acc_r  <= acc_nxt;
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          // The product stays below 2^124, so these bits hold all of it after the shift.
          dvd_r  <= acc_nxt[ACC_W-2 -: DVD_W];
          rem_r  <= '0;
          dcnt_r <= '0;
        end
      end
      FILL_DIV: begin
        dvd_r  <= dvd_nxt;
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r + ($clog2(DIV_STEPS))'(1);
      end
      FILL_ACC: begin
        term_r <= M_W'(dvd_r);
        sum_r  <= sum_r + M_W'(dvd_r);
        k_r    <= k_r + K_W'(1);
        mcnt_r <= 2'd0;
        acc_r  <= '0;
      end
      default: begin
        term_r <= term_r;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/mntf_exp_mem.sv
// Exponent table memory with one write port and one registered read port.
`default_nettype none

module mntf_exp_mem (
  input  wire logic                     clk,
  input  wire mntf_pkg::tbl_wr_t        wr,
  input  wire logic                     rd_en,
  input  wire logic [mntf_pkg::R_W-1:0] rd_addr,
  output logic      [mntf_pkg::M_W-1:0] rd_data
);
  import mntf_pkg::*;

  logic [M_W-1:0] mem_r [TBL_DEPTH];
  logic [M_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Registered read; it holds while the stage behind it is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/midi_note_to_frequency_top.sv
// Top level of the MIDI note to equal-tempered frequency converter.
//
//   Channel  Dir  Handshake              Payload
//   in_      in   in_valid / in_stall    mntf_pkg::in_item_t  (note, last_in)
//   out_     out  out_valid / out_stall  mntf_pkg::out_item_t (freq_hz, clamped, last_out)
//   APB      in   psel, penable, pready  sample_rate at byte address 0
//
// One item per cycle while out_stall is low, through six register stages. Stage one loads at
// the edge that takes the item; the table read sits in stage three.
// After reset the exponent table of 3072 entries is built by a single series engine, with
// in_stall held high; configuration writes are taken meanwhile. Every stage register loads
// whenever its successor can take data, so bubbles close up and out_stall holds only the
// full stages.
`default_nettype none

module midi_note_to_frequency_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mntf_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mntf_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mntf_pkg::APB_AW-1:0] paddr,
  input  wire logic [mntf_pkg::APB_DW-1:0] pwdata,
  output logic      [mntf_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import mntf_pkg::*;

  logic [FREQ_W-1:0] top;
  tbl_wr_t           tbl_wr;
  logic              tbl_ready;
  logic [M_W-1:0]    m3;

  // Stage registers.
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic [D_W-1:0]    d1_r;
  logic              l1_r, l2_r, l3_r, l4_r, l5_r;
  logic [Q_W-1:0]    q2_r, q3_r, q4_r;
  logic [R_W-1:0]    r2_r;
  logic [P_W-1:0]    p4_r;
  logic [T_W-1:0]    t5_r;
  logic              big5_r;
  out_item_t         out_r;

  // Next values.
  logic [D_W-1:0]    d1_nxt;
  logic [X_W-1:0]    u;
  logic [X_W+RECIP3_W-1:0] prod3;
  logic [Q_W-1:0]    qp;
  logic [X_W-1:0]    u_rem;
  logic [Q_W-1:0]    q2_nxt;
  logic [R_W-1:0]    r2_nxt;
  logic [P_W-1:0]    p4_nxt;
  logic [SH_W+1:0]   s_full;
  logic [T_W-1:0]    t5_nxt;
  logic              big5_nxt;
  logic              over;
  out_item_t         out_nxt;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  mntf_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .top     (top)
  );

  mntf_taylor_fill u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tbl_wr),
    .done  (tbl_ready)
  );

  mntf_exp_mem u_mem (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_en   (rdy3),
    .rd_addr (r2_r),
    .rd_data (m3)
  );

  // A stage loads when it is empty or its successor loads.
  assign rdy6     = !out_valid_r || !out_stall;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !tbl_ready || !rdy1;

  // Stage one: offset the note so that A4 lands on zero.
  assign d1_nxt = {in_data.note[NOTE_W-1], in_data.note} - NOTE_OFFSET;

  // Stage two: split into whole octaves and the position inside the octave.
  always_comb begin
    u      = d1_r[D_W-1:DIV_SHIFT] + X_W'(X_BIAS);
    prod3  = (X_W+RECIP3_W)'(u) * (X_W+RECIP3_W)'(RECIP3);
    qp     = prod3[RECIP3_SHIFT +: Q_W];
    u_rem  = u - X_W'(qp) * X_W'(3);
    q2_nxt = qp - Q_W'(Q_BIAS);
    r2_nxt = {u_rem[R_W-DIV_SHIFT-1:0], d1_r[DIV_SHIFT-1:0]};
  end

  // Stage four: scale the mantissa by 440 Hz.
  assign p4_nxt = P_W'(m3) * P_W'(FREQ_A4);

  // Stage five: shift by the octave count; notes twenty octaves up always clamp.
  always_comb begin
    big5_nxt = !q4_r[Q_W-1] && (q4_r >= Q_W'(Q_OVER));
    s_full   = (SH_W+2)'(SHIFT_BASE) - {{(SH_W+2-Q_W){q4_r[Q_W-1]}}, q4_r};
    t5_nxt   = T_W'(p4_r >> s_full[SH_W-1:0]);
  end

  // Stage six: compare with the Nyquist bound.
  always_comb begin
    over             = big5_r || (t5_r > T_W'(top));
    out_nxt.freq_hz  = over ? top : t5_r[FREQ_W-1:0];
    out_nxt.clamped  = over;
    out_nxt.last_out = l5_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid && tbl_ready;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) v5_r        <= v4_r;
      if (rdy6) out_valid_r <= v5_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1_r <= d1_nxt;
      l1_r <= in_data.last_in;
    end
    if (rdy2) begin
      q2_r <= q2_nxt;
      r2_r <= r2_nxt;
      l2_r <= l1_r;
    end
    if (rdy3) begin
      q3_r <= q2_r;
      l3_r <= l2_r;
    end
    if (rdy4) begin
      p4_r <= p4_nxt;
      q4_r <= q3_r;
      l4_r <= l3_r;
    end
    if (rdy5) begin
      t5_r   <= t5_nxt;
      big5_r <= big5_nxt;
      l5_r   <= l4_r;
    end
    if (rdy6) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hdl/mntf_port_checker.sv
// Port-level checker for the note-to-frequency block, bound to its top level.
`default_nettype none

`include "midi_note_to_frequency_top_macros.svh"

module mntf_port_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire mntf_pkg::out_item_t         out_data,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [mntf_pkg::APB_AW-1:0] paddr,
  input wire logic [mntf_pkg::APB_DW-1:0] pwdata,
  input wire logic [mntf_pkg::APB_DW-1:0] prdata
);
  import mntf_pkg::*;

  // A result that is held back stays put.
  `MNTF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // The table is rebuilt after every reset, so no item is taken right away.
  `MNTF_ASSERT_IMP(a_build_stall, !$past(rst_n), in_stall, "item taken before the table was built")

  // Once items flow, the input only stalls when the output does.
  `MNTF_ASSERT_IMP(a_full_rate, $past(rst_n) && !$past(in_stall) && !out_stall, !in_stall, "input stalled with a free output")

  // A sample rate write reads back on the next cycle.
  `MNTF_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && (paddr[APB_AW-1] == REG_SAMPLE_RATE), (paddr[APB_AW-1] != REG_SAMPLE_RATE) || (prdata == APB_DW'($past(pwdata[SR_W-1:0]))), "sample rate readback mismatch")

endmodule

bind midi_note_to_frequency_top mntf_port_checker u_port_checker (.*);

`default_nettype wire
